/* src/sivd_pkg.sv */
// sivd_pkg: shared types and codes for the sparse index variable-length decoder
// no dependencies; imported by every module of the block
package sivd_pkg;

  localparam int unsigned IdxW = 32;

  // coding modes
  localparam logic [1:0] MODE_BYTE   = 2'd0;
  localparam logic [1:0] MODE_LE16   = 2'd1;
  localparam logic [1:0] MODE_LE32   = 2'd2;
  localparam logic [1:0] MODE_ESCAPE = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  // configuration register indexes
  localparam logic CFG_CODING_MODE   = 1'b0;
  localparam logic CFG_FEATURE_COUNT = 1'b1;

  localparam logic [7:0] ESCAPE_BYTE = 8'd255;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_last;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0] feature_index;
    logic [1:0]      status;
    logic            last_of_record;
  } out_item_t;

endpackage

/* src/sparse_index_varlen_decoder.sv */
// sparse_index_varlen_decoder: top level, config registers and result register
// depends on sivd_pkg and sivd_asm
//
// usage
//   in_*  : one record byte per request, record_last marks the final byte
//   out_* : decoded feature index with status (ok, out of range, truncated)
//   cfg_* : register writes, index 0 coding_mode, index 1 feature_count;
//           always ready, write only while no request is in flight
// result: a result appears on out_valid in the cycle after the byte that
//   completes it (or ends the record); bytes that only extend a partial
//   index give no result
// throughput: one byte per cycle unless a result stalls, set by the single
//   result register; in_ready is high whenever it is empty or being drained
// stall: while out_ready is low the held result stays unchanged and
//   in_ready drops, so no byte is taken until the result leaves
// reset: coding_mode 0, feature_count 0, assembler cleared, no result held;
//   writing coding_mode also clears any partial index
module sparse_index_varlen_decoder import sivd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [IdxW-1:0] cfg_data
);

  logic [1:0]      mode_r;
  logic [IdxW-1:0] fcount_r;
  logic            out_valid_r;
  out_item_t       out_data_r;

  logic      step;
  logic      cfg_wr;
  logic      mode_wr;
  logic      res_valid;
  out_item_t res;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign mode_wr   = cfg_wr && (cfg_index == CFG_CODING_MODE);
  assign in_ready  = !out_valid_r || out_ready;
  assign step      = in_valid && in_ready;

  sivd_asm u_asm (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .clear         (mode_wr),
    .item          (in_data),
    .coding_mode   (mode_r),
    .feature_count (fcount_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_BYTE;
      fcount_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_CODING_MODE:   mode_r   <= cfg_data[1:0];
        CFG_FEATURE_COUNT: fcount_r <= cfg_data;
        default:           mode_r   <= mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/sivd_asm.sv */
// sivd_asm: byte assembler state and index decode for one request per cycle
// depends on sivd_pkg
module sivd_asm import sivd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic            clear,
  input  in_item_t        item,
  input  logic [1:0]      coding_mode,
  input  logic [IdxW-1:0] feature_count,
  output logic            res_valid,
  output out_item_t       res
);

  logic [23:0] partial_r, partial_nxt;
  logic [1:0]  gathered_r, gathered_nxt;
  logic        esc_r, esc_nxt;

  logic            done;
  logic [IdxW-1:0] value;
  logic [23:0]     shifted;

  always_comb begin
    shifted = 24'(item.data_byte) << {gathered_r, 3'b000};
  end

  always_comb begin
    done         = 1'b0;
    value        = '0;
    partial_nxt  = partial_r;
    gathered_nxt = gathered_r;
    esc_nxt      = esc_r;
    case (coding_mode)
      MODE_BYTE: begin
        value = IdxW'(item.data_byte);
        done  = 1'b1;
      end
      MODE_LE16: begin
        if (gathered_r != 2'd0) begin
          value = {16'd0, item.data_byte, partial_r[7:0]};
          done  = 1'b1;
        end else begin
          partial_nxt  = 24'(item.data_byte);
          gathered_nxt = 2'd1;
        end
      end
      MODE_LE32: begin
        if (gathered_r == 2'd3) begin
          value = {item.data_byte, partial_r};
          done  = 1'b1;
        end else begin
          partial_nxt  = partial_r | shifted;
          gathered_nxt = gathered_r + 2'd1;
        end
      end
      default: begin
        if (esc_r) begin
          value = IdxW'(ESCAPE_BYTE) + IdxW'(item.data_byte);
          done  = 1'b1;
        end else if (item.data_byte != ESCAPE_BYTE) begin
          value = IdxW'(item.data_byte);
          done  = 1'b1;
        end else begin
          esc_nxt = 1'b1;
        end
      end
    endcase
    if (done || item.record_last) begin
      partial_nxt  = '0;
      gathered_nxt = '0;
      esc_nxt      = 1'b0;
    end
  end

  always_comb begin
    res_valid          = done || item.record_last;
    res.last_of_record = item.record_last;
    if (done) begin
      res.feature_index = value;
      res.status        = (value >= feature_count) ? ST_RANGE : ST_OK;
    end else begin
      res.feature_index = '0;
      res.status        = ST_TRUNCATED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      partial_r  <= '0;
      gathered_r <= '0;
      esc_r      <= 1'b0;
    end else if (step) begin
      partial_r  <= partial_nxt;
      gathered_r <= gathered_nxt;
      esc_r      <= esc_nxt;
    end
  end

endmodule

/* src/sivd_chk.sv */
// sivd_chk: port-level checks of the decoder, bound to the top level
// depends on sivd_pkg and sparse_index_varlen_decoder
module sivd_chk import sivd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // truncation only at record end and carries a zero index
  a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_TRUNCATED |->
      out_data.last_of_record && out_data.feature_index == '0)
    else $error("bad truncation result");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == ST_OK || out_data.status == ST_RANGE ||
      out_data.status == ST_TRUNCATED)
    else $error("undefined status code");

  // input side is never blocked by an empty or draining result register
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("request blocked without a stalled result");

endmodule

bind sparse_index_varlen_decoder sivd_chk u_sivd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
